/* rtl/ascii_decimal_tlv_parser_top_assert.svh */
// ----------------------------------------------------------------------------
// ascii decimal tlv parser assertion macros
// shared property forms for the parser's concurrent checks
// ----------------------------------------------------------------------------
`ifndef ASCII_DECIMAL_TLV_PARSER_TOP_ASSERT_SVH
`define ASCII_DECIMAL_TLV_PARSER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ADTP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ADTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/adtp_pkg.sv */
// ----------------------------------------------------------------------------
// adtp_pkg
// shared types, codes and helpers of the ascii decimal tlv parser
// ----------------------------------------------------------------------------
package adtp_pkg;

  localparam int FIELD_DIGITS_DEF = 3;

  localparam int CHAR_W = 8;
  localparam int NUM_W  = 10;
  localparam int CONS_W = 11;
  localparam int KIND_W = 2;

  localparam logic [NUM_W-1:0]  NUM_MAX  = 10'd1023;
  localparam logic [CONS_W-1:0] CONS_MAX = 11'd2047;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_MSG  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ELEM = 2'd1;
  localparam logic [KIND_W-1:0] KIND_VAL  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd3;

  typedef enum logic [3:0] {
    PH_TOTAL = 4'b0001,
    PH_TAG   = 4'b0010,
    PH_LEN   = 4'b0100,
    PH_VALUE = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [NUM_W-1:0]   total;
    logic [NUM_W-1:0]   tag;
    logic [NUM_W-1:0]   len;
    logic [NUM_W-1:0]   vrem;
    logic [CONS_W-1:0]  consumed;
  } adtp_state_t;

  typedef struct packed {
    logic               valid;
    logic [KIND_W-1:0]  kind;
    logic [NUM_W-1:0]   total_length;
    logic [NUM_W-1:0]   tag;
    logic [NUM_W-1:0]   elem_length;
    logic [CHAR_W-1:0]  value_byte;
    logic               end_of_element;
    logic               end_of_message;
  } adtp_result_t;

  localparam adtp_state_t ST_RESET = '{phase: PH_TOTAL, default: '0};

  // acc*10 + d, saturating at NUM_MAX
  function automatic logic [NUM_W-1:0] accumulate(input logic [NUM_W-1:0] acc,
                                                 input logic [3:0] d);
    logic [NUM_W+3:0] v;
    v = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{NUM_W{1'b0}}, d};
    accumulate = (v > {4'b0000, NUM_MAX}) ? NUM_MAX : v[NUM_W-1:0];
  endfunction

endpackage

/* rtl/adtp_step.sv */
// ----------------------------------------------------------------------------
// adtp_step
// next state and result for one received character
// ----------------------------------------------------------------------------
module adtp_step import adtp_pkg::*; #(
  parameter int FIELD_DIGITS = FIELD_DIGITS_DEF,
  parameter int CNT_W        = 2
) (
  input  logic [CHAR_W-1:0] ch,
  input  adtp_state_t       st,
  input  logic [CNT_W-1:0]  cnt,
  output adtp_state_t       st_nxt,
  output logic [CNT_W-1:0]  cnt_nxt,
  output adtp_result_t      res
);

  localparam int SUM_W = CONS_W + 2;
  localparam logic [CNT_W:0] FD_CNT  = (CNT_W+1)'(FIELD_DIGITS);
  localparam logic [SUM_W-1:0] HDR_B = SUM_W'(2 * FIELD_DIGITS);

  always_comb begin
    logic              is_digit;
    logic [3:0]        d;
    logic [CNT_W:0]    cnt_inc;
    logic              cnt_done;
    logic [NUM_W-1:0]  acc_new;
    logic [NUM_W-1:0]  vrem_dec;
    logic [SUM_W-1:0]  sum;
    logic [CONS_W-1:0] cons_new;

    st_nxt   = st;
    cnt_nxt  = cnt;
    res      = '0;
    is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    d        = ch[3:0];
    cnt_inc  = {1'b0, cnt} + {{CNT_W{1'b0}}, 1'b1};
    cnt_done = (cnt_inc >= FD_CNT);
    acc_new  = '0;
    vrem_dec = (st.vrem != '0) ? (st.vrem - 1'b1) : st.vrem;
    sum      = '0;
    cons_new = '0;

    if (st.phase == PH_VALUE) begin
      res.valid      = 1'b1;
      res.kind       = KIND_VAL;
      res.value_byte = ch;
      st_nxt.vrem    = vrem_dec;
      if (vrem_dec == '0) begin
        res.end_of_element = 1'b1;
        cnt_nxt            = '0;
        if (st.consumed >= {1'b0, st.total}) begin
          res.end_of_message = 1'b1;
          st_nxt             = ST_RESET;
        end else begin
          st_nxt.phase = PH_TAG;
          st_nxt.tag   = '0;
          st_nxt.len   = '0;
          st_nxt.vrem  = '0;
        end
      end
    end else if (!is_digit) begin
      // resync: drop the message, wait for a new total length
      st_nxt    = ST_RESET;
      cnt_nxt   = '0;
      res.valid = 1'b1;
      res.kind  = KIND_ERR;
    end else begin
      cnt_nxt = cnt_inc[CNT_W-1:0];
      case (st.phase)
        PH_TOTAL: begin
          acc_new      = accumulate(st.total, d);
          st_nxt.total = acc_new;
          if (cnt_done) begin
            res.valid        = 1'b1;
            res.kind         = KIND_MSG;
            res.total_length = acc_new;
            cnt_nxt          = '0;
            st_nxt.consumed  = '0;
            if (acc_new == '0) begin
              res.end_of_message = 1'b1;
              st_nxt             = ST_RESET;
            end else begin
              st_nxt.phase = PH_TAG;
            end
          end
        end
        PH_TAG: begin
          acc_new    = accumulate(st.tag, d);
          st_nxt.tag = acc_new;
          if (cnt_done) begin
            cnt_nxt      = '0;
            st_nxt.phase = PH_LEN;
          end
        end
        PH_LEN: begin
          acc_new    = accumulate(st.len, d);
          st_nxt.len = acc_new;
          if (cnt_done) begin
            cnt_nxt         = '0;
            res.valid       = 1'b1;
            res.kind        = KIND_ELEM;
            res.tag         = st.tag;
            res.elem_length = acc_new;
            sum = {2'b00, st.consumed} + {3'b000, acc_new} + HDR_B;
            cons_new = (sum > {2'b00, CONS_MAX}) ? CONS_MAX : sum[CONS_W-1:0];
            st_nxt.consumed = cons_new;
            if (acc_new == '0) begin
              res.end_of_element = 1'b1;
              if (cons_new >= {1'b0, st.total}) begin
                res.end_of_message = 1'b1;
                st_nxt             = ST_RESET;
              end else begin
                st_nxt.phase = PH_TAG;
                st_nxt.tag   = '0;
                st_nxt.len   = '0;
                st_nxt.vrem  = '0;
              end
            end else begin
              st_nxt.vrem  = acc_new;
              st_nxt.phase = PH_VALUE;
            end
          end
        end
        default: begin
          st_nxt  = st;
          cnt_nxt = cnt;
        end
      endcase
    end
  end

endmodule

/* rtl/ascii_decimal_tlv_parser_top.sv */
// ----------------------------------------------------------------------------
// ascii_decimal_tlv_parser_top
// streaming parser for messages of ascii decimal tag/length/value elements
// ----------------------------------------------------------------------------
//  channel | dir | tdata                 | tuser              | tlast
//  in_     | in  | ch                    | -                  | -
//  out_    | out | total_length, tag,    | kind,              | end_of_message
//          |     | elem_length, value_b. | end_of_element     |
//
//  one character per cycle: every character is taken in the cycle it is
//  offered while the result register is empty or being drained
//  the parse state updates at the accepting edge; the result shows in the next cycle
//  in_tready is low only while a result waits and out_tready is low
//  reset (rst_n low, synchronous) clears the parse state and drops any pending result
// ----------------------------------------------------------------------------
module ascii_decimal_tlv_parser_top import adtp_pkg::*; #(
  parameter int FIELD_DIGITS = FIELD_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [9:0] total_length, [19:10] tag,
                                  // [29:20] elem_length, [37:30] value_byte, rest 0
  output logic [2:0]  out_tuser,  // [1:0] kind, [2] end_of_element
  output logic        out_tlast   // end_of_message
);

  `include "ascii_decimal_tlv_parser_top_assert.svh"

  // digit counter only ever holds FIELD_DIGITS-1 at most
  localparam int CNT_W = (FIELD_DIGITS > 1) ? $clog2(FIELD_DIGITS) : 1;
  localparam logic [CNT_W:0] FD_CNT = (CNT_W+1)'(FIELD_DIGITS);

  adtp_state_t      st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  adtp_result_t     res;
  adtp_result_t     out_r;
  logic             out_valid_r, out_valid_nxt;
  logic             in_xfer;
  logic [CNT_W:0]   cnt_ext;

  // skid-free output register: refill in the cycle it drains
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign cnt_ext   = {1'b0, cnt_r};

  adtp_step #(
    .FIELD_DIGITS (FIELD_DIGITS),
    .CNT_W        (CNT_W)
  ) u_step (
    .ch      (in_tdata),
    .st      (st_r),
    .cnt     (cnt_r),
    .st_nxt  (st_nxt),
    .cnt_nxt (cnt_nxt),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = res.valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // parse state and result-valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        st_r  <= st_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  // result payload, loaded with every accepted character
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r.value_byte, out_r.elem_length,
                       out_r.tag, out_r.total_length};
  assign out_tuser  = {out_r.end_of_element, out_r.kind};
  assign out_tlast  = out_r.end_of_message;

  // ---- assertions ----
  `ADTP_ASSERT_SAME(a_cnt_range, 1'b1, cnt_ext < FD_CNT,
    "digit counter reached the field width")
  `ADTP_ASSERT_SAME(a_vrem_value, st_r.phase == PH_VALUE, st_r.vrem != '0,
    "value phase with no bytes remaining")
  `ADTP_ASSERT_SAME(a_vrem_idle, st_r.phase != PH_VALUE, st_r.vrem == '0,
    "bytes remaining outside the value phase")
  `ADTP_ASSERT_SAME(a_err_clean, out_valid_r && out_r.kind == KIND_ERR,
    out_tdata == '0 && !out_tlast && !out_r.end_of_element,
    "format error carries payload")
  `ADTP_ASSERT_NEXT(a_err_resync, in_xfer && res.valid && res.kind == KIND_ERR,
    out_tvalid && st_r.phase == PH_TOTAL && cnt_r == '0,
    "format error did not resync to total length")

endmodule
